[hdl/fxa_pkg.sv]
package fxa_pkg;

    // Fixed field widths
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 5;
    localparam int DIGIT_W = 4;

    // Character counts, wide enough for the result limit
    localparam int CNT_W        = 6;
    localparam int RESULT_LIMIT = 32;

    // Defaults for the top-level parameters
    localparam int DEF_FRAC_BITS     = 32;
    localparam int DEF_MAX_PRECISION = 20;

    localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = 5'd6;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

endpackage

[hdl/fxa_dabble.sv]
module fxa_dabble #(
    parameter int INT_W  = 32,
    parameter int DIGITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [INT_W-1:0]                    int_bits,
    output logic                                done,
    output logic [DIGITS*fxa_pkg::DIGIT_W-1:0]  bcd
);
    import fxa_pkg::*;

    localparam int CW = $clog2(INT_W + 1);
    localparam int BW = DIGITS * DIGIT_W;

    logic [INT_W-1:0] shift_reg;
    logic [BW-1:0]    bcd_reg;
    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [BW-1:0]    adj;

    // add-3 correction on every digit, ahead of the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == CW'(1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(INT_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= int_bits;
            bcd_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[INT_W-2:0], 1'b0};
            bcd_reg   <= {adj[BW-2:0], shift_reg[INT_W-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("conversion started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done raised while still shifting");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg != '0))
        else $error("busy with no bits left");

endmodule

[hdl/fixed_to_decimal_ascii.sv]
// Signed fixed-point to decimal ASCII string, one character per request.
// After accept, the double-dabble shift of the integer bits runs and then the
// S_SIZE step; the first character is registered after both.
// A new value is accepted only once the previous string is fully loaded; its N
// characters are emitted at one per cycle while the output is not stalled.
// Reset (rst_n, async low): idle, output empty, fraction_digits back to 6.
module fixed_to_decimal_ascii #(
    parameter int FRAC_BITS     = fxa_pkg::DEF_FRAC_BITS,
    parameter int MAX_PRECISION = fxa_pkg::DEF_MAX_PRECISION
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // fraction-digit register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fxa_pkg::CFG_W-1:0]    fraction_digits,
    // value requests
    input  logic                         value_valid,
    output logic                         value_stall,
    input  logic [fxa_pkg::VALUE_W-1:0]  fixed_value,
    // character requests
    output logic                         char_valid,
    input  logic                         char_stall,
    output logic [fxa_pkg::CHAR_W-1:0]   ascii_char,
    output logic                         last_char
);
    import fxa_pkg::*;

    // Integer bits, decimal digits to hold them (0.31 > log10 2)
    localparam int INT_W  = VALUE_W - FRAC_BITS;
    localparam int DIGITS = (INT_W * 31) / 100 + 1;
    localparam int NDW    = $clog2(DIGITS + 1);
    localparam int IDXW   = $clog2(DIGITS);
    localparam int TW     = FRAC_BITS + 4;

    localparam logic [CNT_W-1:0] LIMIT  = CNT_W'(RESULT_LIMIT);
    localparam logic [CNT_W-1:0] PREC_MAX = CNT_W'(MAX_PRECISION);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CONV  = 7'b0000010,
        S_SIZE  = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_INT   = 7'b0010000,
        S_POINT = 7'b0100000,
        S_FRAC  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       frac_digits_reg;
    logic                   neg_reg, neg_next;
    logic [FRAC_BITS-1:0]   frac_reg, frac_next;
    logic [IDXW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]       prec_reg, prec_next;
    logic [CNT_W-1:0]       fcnt_reg, fcnt_next;
    logic                   char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic                   accept;
    logic                   out_free;
    logic                   load;
    logic [VALUE_W-1:0]     mag;
    logic                   conv_done;
    logic [DIGITS*DIGIT_W-1:0] bcd;
    logic [DIGIT_W-1:0]     digit_arr [DIGITS];
    logic [NDW-1:0]         ndig;
    logic [CNT_W-1:0]       used;
    logic [CNT_W-1:0]       room;
    logic [CNT_W-1:0]       prec_cap;
    logic [TW-1:0]          ten;

    // Config: always ready, only written while idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_digits_reg <= FRAC_DIGITS_RESET;
        else if (cfg_valid && cfg_ready)
            frac_digits_reg <= fraction_digits;
    end

    // Input side: one value at a time
    assign value_stall = (state_reg != S_IDLE);
    assign accept      = value_valid && !value_stall;

    // Magnitude; the most negative value maps to 2^63 exactly
    assign mag = fixed_value[VALUE_W-1] ? (~fixed_value + VALUE_W'(1)) : fixed_value;

    fxa_dabble #(
        .INT_W  (INT_W),
        .DIGITS (DIGITS)
    ) u_dabble (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .int_bits (mag[VALUE_W-1:FRAC_BITS]),
        .done     (conv_done),
        .bcd      (bcd)
    );

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
            digit_arr[i] = bcd[i*DIGIT_W +: DIGIT_W];
    end

    // Significant digit count: highest nonzero digit, at least one
    always_comb
    begin
        ndig = NDW'(1);
        for (int i = 1; i < DIGITS; i++)
        begin
            if (digit_arr[i] != '0)
                ndig = NDW'(i + 1);
        end
    end

    // Fraction digit count: saturate at MAX_PRECISION, then fit the string limit
    assign used     = CNT_W'(neg_reg) + CNT_W'(ndig) + CNT_W'(1);
    assign room     = (used >= LIMIT) ? '0 : (LIMIT - used);
    assign prec_cap = (CNT_W'(frac_digits_reg) > PREC_MAX) ? PREC_MAX
                                                            : CNT_W'(frac_digits_reg);

    // Next fraction digit: frac * 10 = frac * 8 + frac * 2
    assign ten = TW'({frac_reg, 3'b000}) + TW'({frac_reg, 1'b0});

    // Output register takes a new character when empty or being drained
    assign out_free = !char_valid_reg || !char_stall;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        frac_next  = frac_reg;
        idx_next   = idx_reg;
        prec_next  = prec_reg;
        fcnt_next  = fcnt_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = fixed_value[VALUE_W-1];
                    frac_next  = mag[FRAC_BITS-1:0];
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                    state_next = S_SIZE;
            end
            S_SIZE:
            begin
                idx_next   = IDXW'(ndig - NDW'(1));
                prec_next  = (prec_cap > room) ? room : prec_cap;
                state_next = neg_reg ? S_SIGN : S_INT;
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = S_INT;
                end
            end
            S_INT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    char_next = CHAR_ZERO + {4'b0000, digit_arr[idx_reg]};
                    last_next = 1'b0;
                    if (idx_reg == '0)
                        state_next = S_POINT;
                    else
                        idx_next = idx_reg - IDXW'(1);
                end
            end
            S_POINT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    char_next  = CHAR_POINT;
                    last_next  = (prec_reg == '0);
                    fcnt_next  = prec_reg;
                    state_next = (prec_reg == '0) ? S_IDLE : S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    char_next = CHAR_ZERO + {4'b0000, ten[TW-1:FRAC_BITS]};
                    last_next = (fcnt_reg == CNT_W'(1));
                    frac_next = ten[FRAC_BITS-1:0];
                    fcnt_next = fcnt_reg - CNT_W'(1);
                    if (fcnt_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign char_valid_next = load ? 1'b1 : (char_valid_reg && char_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        frac_reg <= frac_next;
        idx_reg  <= idx_next;
        prec_reg <= prec_next;
        fcnt_reg <= fcnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_valid = char_valid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == S_CONV))
        else $error("conversion finished outside the wait state");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid_reg |-> (char_reg == CHAR_MINUS || char_reg == CHAR_POINT ||
                            (char_reg >= CHAR_ZERO && char_reg <= CHAR_NINE)))
        else $error("character outside the output alphabet");

    a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRAC) |-> (fcnt_reg != '0 && fcnt_reg <= PREC_MAX))
        else $error("fraction digit count out of range");

endmodule
